// File: rtl/frm_pkg.sv
package frm_pkg;

	localparam int MAX_SAMPLES = 4096;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 31;
	localparam int SUM_W    = 42;
	localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
	localparam int FCNT_W   = 13;
	localparam int FS_W     = 24;
	localparam int RMS_W    = 24;
	localparam int FRAC_W   = 8;

	localparam int MEAN_W   = 31;
	localparam int ROOT_W   = 24;
	localparam int RAD_W    = 2 * ROOT_W;
	localparam int RREM_W   = ROOT_W + 2;
	localparam int PROD_W   = ROOT_W + FS_W;
	localparam int RND_SH   = 23;

	localparam int DIV_STEPS  = SUM_W;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QLVL_W  = $clog2(Q_DEPTH + 1);

	localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
	localparam logic [FS_W-1:0]  FS_RESET  = FS_W'(3300000);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_sample;
	} in_item_t;

	typedef struct packed {
		logic [RMS_W-1:0]  rms_microvolts;
		logic [FCNT_W-1:0] frame_count;
		logic              overflow;
	} out_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
		logic             overflow;
	} frame_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_ROOT,
		BK_MUL,
		BK_OUT
	} back_state_t;

endpackage

// File: rtl/frm_front.sv
module frm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  frm_pkg::in_item_t    item,
	input  logic [frm_pkg::QLVL_W-1:0] q_level,
	output logic                 q_push,
	output frm_pkg::frame_t      q_data
);
	import frm_pkg::*;

	logic               accept;
	logic               valid_s1, last_s1;
	logic [MAG_W-1:0]   mag_s1;
	logic               valid_s2, last_s2;
	logic [SQ_W-1:0]    sq_s2;
	logic [2*MAG_W-1:0] prod;
	logic [SUM_W-1:0]   sum_q, sum_new;
	logic [CNT_W-1:0]   cnt_q, cnt_new;
	logic               ovf_q, ovf_new;
	logic [SUM_W:0]     sum_add;
	logic               room;
	logic [1:0]         pending;
	logic [QLVL_W:0]    committed;

	// Every frame end still in the pipeline must find a queue slot.
	assign pending   = 2'(valid_s1 & last_s1) + 2'(valid_s2 & last_s2);
	assign committed = (QLVL_W+1)'(q_level) + (QLVL_W+1)'(pending);
	assign full      = committed >= (QLVL_W+1)'(Q_DEPTH);
	assign accept    = push & ~full;

	assign prod = mag_s1 * mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= item.sample[SAMPLE_W-1] ? MAG_W'(-item.sample) : MAG_W'(item.sample);
		last_s1 <= item.last_sample;
		sq_s2   <= prod[SQ_W-1:0];
		last_s2 <= last_s1;
	end

	always_comb begin
		room    = cnt_q < CNT_W'(MAX_SAMPLES);
		sum_add = {1'b0, sum_q} + (SUM_W+1)'(sq_s2);
		sum_new = sum_q;
		cnt_new = cnt_q;
		ovf_new = ovf_q;
		if (room) begin
			sum_new = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
			cnt_new = cnt_q + CNT_W'(1);
		end else begin
			ovf_new = 1'b1;
		end
	end

	assign q_push         = valid_s2 & last_s2;
	assign q_data.sum      = sum_new;
	assign q_data.count    = cnt_new;
	assign q_data.overflow = ovf_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (valid_s2) begin
			if (last_s2) begin
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_new;
				cnt_q <= cnt_new;
				ovf_q <= ovf_new;
			end
		end
	end

endmodule

// File: rtl/frm_queue.sv
module frm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  frm_pkg::frame_t     wr_data,
	input  logic                pop,
	output frm_pkg::frame_t     rd_data,
	output logic                empty,
	output logic [frm_pkg::QLVL_W-1:0] level
);
	import frm_pkg::*;

	frame_t            mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	assign level   = level_q;
	assign empty   = level_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			level_q <= level_q + QLVL_W'(push) - QLVL_W'(pop);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> level_q != QLVL_W'(Q_DEPTH))
		else $error("Frame queue written while full.");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> level_q != '0)
		else $error("Frame queue read while empty.");

endmodule

// File: rtl/frm_back.sv
module frm_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  frm_pkg::frame_t          q_data,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  logic [frm_pkg::FS_W-1:0] full_scale,
	output logic                     empty,
	input  logic                     pop,
	output frm_pkg::out_item_t       result
);
	import frm_pkg::*;

	back_state_t        state_q, state_d;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   quo_q;
	logic [CNT_W-1:0]   drem_q, div_q;
	logic               cnt_zero_q;
	logic [FCNT_W-1:0]  fcnt_q;
	logic               ovf_q;
	logic [RAD_W-1:0]   rad_q;
	logic [RREM_W-1:0]  rrem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [PROD_W-1:0]  prod_q;
	logic               out_valid_q;
	out_item_t          result_q;

	logic [CNT_W:0]     dshift;
	logic               dfit;
	logic [RREM_W+1:0]  rshift, rtrial;
	logic               rfit;
	logic [PROD_W:0]    rounded;
	logic [PROD_W-RND_SH:0] scaled;
	logic [RMS_W-1:0]   rms;
	logic               out_free, load_out;
	logic               last_step;

	assign out_free = ~out_valid_q | pop;

	always_comb begin
		dshift = {drem_q, quo_q[SUM_W-1]};
		dfit   = dshift >= (CNT_W+1)'(div_q);

		rshift = {rrem_q, rad_q[RAD_W-1 -: 2]};
		rtrial = (RREM_W+2)'({root_q, 2'b01});
		rfit   = rshift >= rtrial;

		rounded = {1'b0, prod_q} + (PROD_W+1)'(1 << (RND_SH - 1));
		scaled  = rounded[PROD_W:RND_SH];
		rms     = (|scaled[PROD_W-RND_SH:RMS_W]) ? {RMS_W{1'b1}} : scaled[RMS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		last_step = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				last_step = step_q == STEP_W'(DIV_STEPS - 1);
				if (last_step) begin
					state_d = BK_ROOT;
				end
			end
			BK_ROOT: begin
				last_step = step_q == STEP_W'(ROOT_STEPS - 1);
				if (last_step) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_OUT;
			end
			BK_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	function automatic logic [MEAN_W-1:0] mean_next(input logic [SUM_W-1:0] quo,
			input logic bit_in, input logic zero);
		logic [SUM_W-1:0] q;
		q = {quo[SUM_W-2:0], bit_in};
		return zero ? '0 : q[MEAN_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				quo_q      <= q_data.sum;
				drem_q     <= '0;
				div_q      <= q_data.count;
				cnt_zero_q <= q_data.count == '0;
				fcnt_q     <= q_data.count[FCNT_W-1:0];
				ovf_q      <= q_data.overflow;
				step_q     <= '0;
			end
			BK_DIV: begin
				quo_q  <= {quo_q[SUM_W-2:0], dfit};
				drem_q <= dfit ? CNT_W'(dshift - (CNT_W+1)'(div_q)) : dshift[CNT_W-1:0];
				step_q <= last_step ? '0 : step_q + STEP_W'(1);
				if (last_step) begin
					rrem_q <= '0;
					root_q <= '0;
				end
			end
			BK_ROOT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				rrem_q <= rfit ? RREM_W'(rshift - rtrial) : rshift[RREM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], rfit};
				step_q <= step_q + STEP_W'(1);
			end
			BK_MUL: begin
				prod_q <= root_q * full_scale;
			end
			BK_OUT: begin
				step_q <= '0;
			end
			default: begin
				step_q <= '0;
			end
		endcase
		// The radicand is the mean with 2 * FRAC_W fraction bits appended.
		if (state_q == BK_DIV && last_step) begin
			rad_q <= RAD_W'({mean_next(quo_q, dfit, cnt_zero_q), {(2*FRAC_W){1'b0}}});
		end
		if (load_out) begin
			result_q.rms_microvolts <= rms;
			result_q.frame_count    <= fcnt_q;
			result_q.overflow       <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty  = ~out_valid_q;
	assign result = result_q;

	a_root_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_ROOT |-> step_q < STEP_W'(ROOT_STEPS))
		else $error("Square root ran past its last step.");

	a_div_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_DIV && step_q == STEP_W'(DIV_STEPS - 1) |=> state_q == BK_ROOT)
		else $error("Division did not hand over to the square root.");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_OUT && out_free |=> out_valid_q && state_q == BK_IDLE)
		else $error("Finished result was not presented.");

endmodule

// File: rtl/frame_rms_meter_core.sv
// RMS meter for frames of signed 16-bit converter samples. Samples enter one per
// clock while full is low; each is squared and added to a saturating 42-bit sum,
// and the flagged last sample closes the frame, whose sum, count and overflow flag
// go into a four-entry queue. A sequential back end divides the sum by the count in
// 42 steps, one quotient bit each, takes the square root with 8 fraction bits in 24
// steps, one root bit each, scales by the full-scale register with one 24 x 24
// multiply and rounds. Frames long enough for the back end to finish the previous
// one stream at one sample per clock; shorter frames fill the queue and full is
// raised until the back end catches up. At most 4096 samples count per frame; further
// samples are dropped and the result carries the overflow flag. The user must write
// the full-scale register only while the block is idle; this is not enforced.
module frame_rms_meter_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  frm_pkg::in_item_t        item,
	output logic                     empty,
	input  logic                     pop,
	output frm_pkg::out_item_t       result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [frm_pkg::FS_W-1:0] cfg_data
);
	import frm_pkg::*;

	logic [FS_W-1:0]   fs_q;
	logic              q_push, q_pop, q_empty;
	logic [QLVL_W-1:0] q_level;
	frame_t            q_wr, q_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= FS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fs_q <= cfg_data;
		end
	end

	frm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_level (q_level),
		.q_push  (q_push),
		.q_data  (q_wr)
	);

	frm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty),
		.level   (q_level)
	);

	frm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_rd),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.full_scale (fs_q),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
